// ===== hdl/glzw_pkg.sv =====
// ----------------------------------------------------------------------------
// glzw_pkg
// Shared types and constants of the GIF LZW encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package glzw_pkg;

  // Default parameter values.
  localparam int HASH_BITS_DEF = 13;
  localparam int MAX_CODES_DEF = 4096;
  localparam int ROOT_BITS_DEF = 8;

  // Fixed widths of the code stream.
  localparam int CODE_W  = 12;
  localparam int WIDTH_W = 4;
  localparam int EPOCH_W = 8;
  localparam int PEND_W  = 19;
  localparam int CNT_W   = 5;
  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  // Output queue sizing.
  localparam int OQ_DEPTH   = 16;
  localparam int OQ_PTR_W   = 4;
  localparam int STEP_BYTES = 7;
  localparam int MAX_OUT    = 4;

  // Input queue sizing.
  localparam int FQ_DEPTH = 2;
  localparam int FQ_PTR_W = 1;

  typedef struct packed {
    logic [7:0] pixel_index;
    logic       last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       run_end;
    logic       frame_end;
  } out_item_t;

  // End-of-item notice from the engine to the output queue.
  typedef struct packed {
    logic done;
    logic last;
  } step_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIPE,
    ST_HASH,
    ST_READ,
    ST_CMP,
    ST_SEND,
    ST_DRAIN,
    ST_PAD,
    ST_FIN
  } back_state_t;

endpackage

`default_nettype wire

// ===== hdl/glzw_front.sv =====
// ----------------------------------------------------------------------------
// glzw_front
// Two-entry input queue that decouples the pixel source from the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module glzw_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire glzw_pkg::in_item_t in_item,
  input  wire logic              hold,
  output logic                   in_full,
  output logic                   item_valid,
  output glzw_pkg::in_item_t     item,
  input  wire logic              item_pop
);

  localparam int PW = glzw_pkg::FQ_PTR_W;

  glzw_pkg::in_item_t q_r [glzw_pkg::FQ_DEPTH];
  logic [PW:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic        take;

  // Queue is full when the pointers differ only in the wrap bit; in_full is also high during hold.
  assign in_full    = ((wr_r - rd_r) == (PW+1)'(glzw_pkg::FQ_DEPTH)) || hold;
  assign take       = in_push && !in_full;
  assign item_valid = (wr_r != rd_r);
  assign item       = q_r[rd_r[PW-1:0]];

  always_comb begin
    wr_nxt = wr_r + (PW+1)'(take);
    rd_nxt = rd_r + (PW+1)'(item_pop && item_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      q_r[wr_r[PW-1:0]] <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/glzw_back.sv =====
// ----------------------------------------------------------------------------
// glzw_back
// LZW engine: hash dictionary walk, code list and LSB-first bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

module glzw_back #(
  parameter int HASH_BITS = glzw_pkg::HASH_BITS_DEF,
  parameter int MAX_CODES = glzw_pkg::MAX_CODES_DEF,
  parameter int ROOT_BITS = glzw_pkg::ROOT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               item_valid,
  input  wire glzw_pkg::in_item_t item,
  output logic                    item_pop,
  input  wire logic               room,
  output logic                    push,
  output logic [7:0]              push_byte,
  output glzw_pkg::step_t         step,
  output logic                    init_busy
);

  localparam int CW    = glzw_pkg::CODE_W;
  localparam int WW    = glzw_pkg::WIDTH_W;
  localparam int EW    = glzw_pkg::EPOCH_W;
  localparam int PW    = glzw_pkg::PEND_W;
  localparam int NW    = glzw_pkg::CNT_W;
  localparam int KEY_W = CW + ROOT_BITS;
  localparam int SLOTS = 1 << HASH_BITS;
  localparam int MEM_W = EW + KEY_W + CW;
  localparam logic [CW-1:0] CLEAR_CODE = CW'(1 << ROOT_BITS);
  localparam logic [CW-1:0] END_CODE   = CW'((1 << ROOT_BITS) + 1);
  localparam logic [CW-1:0] FIRST_FREE = CW'((1 << ROOT_BITS) + 2);
  localparam logic [WW-1:0] INIT_WIDTH = WW'(ROOT_BITS + 1);
  localparam logic [CW:0]   MAX_C      = (CW+1)'(MAX_CODES);
  localparam logic [EW-1:0] EPOCH_TOP  = '1;

  glzw_pkg::back_state_t state_r, state_nxt;

  logic [MEM_W-1:0]     dict_mem [SLOTS];
  logic [MEM_W-1:0]     rd_r;
  logic                 mem_we;
  logic [HASH_BITS-1:0] mem_wa;
  logic [MEM_W-1:0]     mem_wd;

  logic [ROOT_BITS-1:0] pix_r, pix_nxt;
  logic                 last_r, last_nxt;
  logic [CW-1:0]        prefix_r, prefix_nxt;
  logic [CW-1:0]        nfc_r, nfc_nxt;
  logic [WW-1:0]        width_r, width_nxt;
  logic                 in_frame_r, in_frame_nxt;
  logic [EW-1:0]        epoch_r, epoch_nxt;
  logic                 wipe_r, wipe_nxt;
  logic                 init_r, init_nxt;
  logic [HASH_BITS-1:0] wipe_idx_r, wipe_idx_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [HASH_BITS-1:0] idx_r, idx_nxt;
  logic [CW-1:0]        codes_r [4];
  logic [CW-1:0]        codes_nxt [4];
  logic [WW-1:0]        cw_r [4];
  logic [WW-1:0]        cw_nxt [4];
  logic [2:0]           ncodes_r, ncodes_nxt;
  logic [2:0]           sidx_r, sidx_nxt;
  logic [PW-1:0]        pend_r, pend_nxt;
  logic [NW-1:0]        pcnt_r, pcnt_nxt;

  logic [EW-1:0]        rd_epoch;
  logic [KEY_W-1:0]     rd_key;
  logic [CW-1:0]        rd_code;
  logic                 slot_free, hit, start;
  logic [31:0]          prod;
  logic [CW-1:0]        sel_mask;

  // Fields of the registered dictionary read.
  assign rd_epoch  = rd_r[MEM_W-1 -: EW];
  assign rd_key    = rd_r[CW +: KEY_W];
  assign rd_code   = rd_r[CW-1:0];
  assign slot_free = (rd_epoch != epoch_r);
  assign hit       = !slot_free && (rd_key == key_r);
  assign start     = !wipe_r && item_valid && room;
  assign init_busy = init_r;
  assign prod      = 32'(key_r) * glzw_pkg::HASH_MULT;
  assign sel_mask  = CW'((CW+1)'(1) << cw_r[sidx_r[1:0]]) - CW'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      glzw_pkg::ST_IDLE: begin
        if (wipe_r) begin
          state_nxt = glzw_pkg::ST_WIPE;
        end else if (start) begin
          state_nxt = in_frame_r ? glzw_pkg::ST_HASH : glzw_pkg::ST_SEND;
        end
      end
      glzw_pkg::ST_WIPE: begin
        if (wipe_idx_r == '1) state_nxt = glzw_pkg::ST_IDLE;
      end
      glzw_pkg::ST_HASH: state_nxt = glzw_pkg::ST_READ;
      glzw_pkg::ST_READ: state_nxt = glzw_pkg::ST_CMP;
      glzw_pkg::ST_CMP: begin
        if (slot_free) begin
          state_nxt = glzw_pkg::ST_SEND;
        end else if (hit) begin
          state_nxt = last_r ? glzw_pkg::ST_SEND : glzw_pkg::ST_FIN;
        end else begin
          state_nxt = glzw_pkg::ST_READ;
        end
      end
      glzw_pkg::ST_SEND: state_nxt = glzw_pkg::ST_DRAIN;
      glzw_pkg::ST_DRAIN: begin
        if (pcnt_r >= NW'(8)) begin
          state_nxt = glzw_pkg::ST_DRAIN;
        end else if (sidx_r < ncodes_r) begin
          state_nxt = glzw_pkg::ST_SEND;
        end else if (last_r && (pcnt_r != '0)) begin
          state_nxt = glzw_pkg::ST_PAD;
        end else begin
          state_nxt = glzw_pkg::ST_FIN;
        end
      end
      glzw_pkg::ST_PAD: state_nxt = glzw_pkg::ST_FIN;
      glzw_pkg::ST_FIN: state_nxt = glzw_pkg::ST_IDLE;
      default: state_nxt = glzw_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    logic [CW:0]     nfc1;
    logic [WW-1:0]   w;
    logic [2:0]      n;
    nfc1         = {1'b0, nfc_r} + (CW+1)'(1);
    w            = width_r;
    n            = '0;
    pix_nxt      = pix_r;
    last_nxt     = last_r;
    prefix_nxt   = prefix_r;
    nfc_nxt      = nfc_r;
    width_nxt    = width_r;
    in_frame_nxt = in_frame_r;
    epoch_nxt    = epoch_r;
    wipe_nxt     = wipe_r;
    init_nxt     = init_r;
    wipe_idx_nxt = wipe_idx_r;
    key_nxt      = key_r;
    idx_nxt      = idx_r;
    codes_nxt    = codes_r;
    cw_nxt       = cw_r;
    ncodes_nxt   = ncodes_r;
    sidx_nxt     = sidx_r;
    pend_nxt     = pend_r;
    pcnt_nxt     = pcnt_r;
    mem_we       = 1'b0;
    mem_wa       = idx_r;
    mem_wd       = {epoch_r, key_r, nfc_r};
    item_pop     = 1'b0;
    push         = 1'b0;
    push_byte    = pend_r[7:0];
    step         = '0;
    unique case (state_r)
      // Take an item; the first pixel of a frame restarts the dictionary.
      glzw_pkg::ST_IDLE: begin
        if (start) begin
          item_pop = 1'b1;
          pix_nxt  = item.pixel_index[ROOT_BITS-1:0];
          last_nxt = item.last_pixel;
          sidx_nxt = '0;
          if (!in_frame_r) begin
            width_nxt    = INIT_WIDTH;
            nfc_nxt      = FIRST_FREE;
            in_frame_nxt = 1'b1;
            prefix_nxt   = CW'(item.pixel_index[ROOT_BITS-1:0]);
            if (epoch_r == EPOCH_TOP) begin
              epoch_nxt = EW'(1);
              wipe_nxt  = 1'b1;
            end else begin
              epoch_nxt = epoch_r + EW'(1);
            end
            codes_nxt[0] = CLEAR_CODE;
            cw_nxt[0]    = INIT_WIDTH;
            ncodes_nxt   = 3'd1;
            if (item.last_pixel) begin
              codes_nxt[1] = CW'(item.pixel_index[ROOT_BITS-1:0]);
              cw_nxt[1]    = INIT_WIDTH;
              codes_nxt[2] = END_CODE;
              cw_nxt[2]    = INIT_WIDTH;
              ncodes_nxt   = 3'd3;
            end
          end else begin
            key_nxt = {prefix_r, item.pixel_index[ROOT_BITS-1:0]};
          end
        end
      end
      // Sweep the dictionary back to the unused epoch.
      glzw_pkg::ST_WIPE: begin
        mem_we       = 1'b1;
        mem_wa       = wipe_idx_r;
        mem_wd       = '0;
        wipe_idx_nxt = wipe_idx_r + HASH_BITS'(1);
        if (wipe_idx_r == '1) begin
          wipe_nxt  = 1'b0;
          init_nxt  = 1'b0;
          epoch_nxt = EW'(1);
        end
      end
      glzw_pkg::ST_HASH: begin
        idx_nxt = prod[31 -: HASH_BITS];
      end
      glzw_pkg::ST_READ: begin
      end
      // Free slot: add the pair; hit: extend prefix; else next slot.
      glzw_pkg::ST_CMP: begin
        if (slot_free) begin
          mem_we       = 1'b1;
          codes_nxt[0] = prefix_r;
          cw_nxt[0]    = width_r;
          n            = 3'd1;
          nfc_nxt      = nfc1[CW-1:0];
          if (nfc1 >= MAX_C) begin
            codes_nxt[1] = CLEAR_CODE;
            cw_nxt[1]    = width_r;
            n            = 3'd2;
            w            = INIT_WIDTH;
            nfc_nxt      = FIRST_FREE;
            if (epoch_r == EPOCH_TOP) begin
              epoch_nxt = EW'(1);
              wipe_nxt  = 1'b1;
            end else begin
              epoch_nxt = epoch_r + EW'(1);
            end
          end else if (nfc1 > ((CW+1)'(1) << width_r)) begin
            w = width_r + WW'(1);
          end
          width_nxt  = w;
          prefix_nxt = CW'(pix_r);
          if (last_r) begin
            codes_nxt[n[1:0]]         = CW'(pix_r);
            cw_nxt[n[1:0]]            = w;
            codes_nxt[n[1:0] + 2'd1]  = END_CODE;
            cw_nxt[n[1:0] + 2'd1]     = w;
            n                         = n + 3'd2;
          end
          ncodes_nxt = n;
        end else if (hit) begin
          prefix_nxt = rd_code;
          ncodes_nxt = '0;
          if (last_r) begin
            codes_nxt[0] = rd_code;
            cw_nxt[0]    = width_r;
            codes_nxt[1] = END_CODE;
            cw_nxt[1]    = width_r;
            ncodes_nxt   = 3'd2;
          end
        end else begin
          idx_nxt = idx_r + HASH_BITS'(1);
        end
      end
      // Merge one code above the pending bits.
      glzw_pkg::ST_SEND: begin
        pend_nxt = pend_r | (PW'(codes_r[sidx_r[1:0]] & sel_mask) << pcnt_r);
        pcnt_nxt = pcnt_r + NW'(cw_r[sidx_r[1:0]]);
        sidx_nxt = sidx_r + 3'd1;
      end
      // Drain whole bytes, one a cycle.
      glzw_pkg::ST_DRAIN: begin
        if (pcnt_r >= NW'(8)) begin
          push     = 1'b1;
          pend_nxt = pend_r >> 8;
          pcnt_nxt = pcnt_r - NW'(8);
        end
      end
      glzw_pkg::ST_PAD: begin
        push     = 1'b1;
        pend_nxt = '0;
        pcnt_nxt = '0;
      end
      glzw_pkg::ST_FIN: begin
        step.done = 1'b1;
        step.last = last_r;
        if (last_r) in_frame_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= glzw_pkg::ST_IDLE;
      prefix_r   <= '0;
      nfc_r      <= FIRST_FREE;
      width_r    <= INIT_WIDTH;
      in_frame_r <= 1'b0;
      epoch_r    <= EW'(1);
      wipe_r     <= 1'b1;
      init_r     <= 1'b1;
      wipe_idx_r <= '0;
      pend_r     <= '0;
      pcnt_r     <= '0;
      ncodes_r   <= '0;
      sidx_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      prefix_r   <= prefix_nxt;
      nfc_r      <= nfc_nxt;
      width_r    <= width_nxt;
      in_frame_r <= in_frame_nxt;
      epoch_r    <= epoch_nxt;
      wipe_r     <= wipe_nxt;
      init_r     <= init_nxt;
      wipe_idx_r <= wipe_idx_nxt;
      pend_r     <= pend_nxt;
      pcnt_r     <= pcnt_nxt;
      ncodes_r   <= ncodes_nxt;
      sidx_r     <= sidx_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pix_r   <= pix_nxt;
    last_r  <= last_nxt;
    key_r   <= key_nxt;
    idx_r   <= idx_nxt;
    codes_r <= codes_nxt;
    cw_r    <= cw_nxt;
  end

  // Dictionary memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) dict_mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (state_r == glzw_pkg::ST_READ) rd_r <= dict_mem[idx_r];
  end

endmodule

`default_nettype wire

// ===== hdl/glzw_outq.sv =====
// ----------------------------------------------------------------------------
// glzw_outq
// Output byte queue; releases at most four bytes per item and flags them.
// ----------------------------------------------------------------------------
`default_nettype none

module glzw_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire logic [7:0]      push_byte,
  input  wire glzw_pkg::step_t step,
  output logic                 room,
  output glzw_pkg::out_item_t  out_item,
  output logic                 out_empty,
  input  wire logic            out_pop
);

  localparam int PW = glzw_pkg::OQ_PTR_W;

  logic [7:0]  byte_r [glzw_pkg::OQ_DEPTH];
  logic        rend_r [glzw_pkg::OQ_DEPTH];
  logic        fend_r [glzw_pkg::OQ_DEPTH];
  logic [PW:0] wr_r, wr_nxt, rd_r, rd_nxt, rel_r, rel_nxt;
  logic [PW:0] avail, n;

  // Bytes written but not yet handed to an item form the backlog.
  assign avail = wr_r - rel_r;
  assign n     = (avail > (PW+1)'(glzw_pkg::MAX_OUT)) ? (PW+1)'(glzw_pkg::MAX_OUT) : avail;
  assign room  = (wr_r - rd_r) <= (PW+1)'(glzw_pkg::OQ_DEPTH - glzw_pkg::STEP_BYTES);
  assign out_empty          = (rd_r == rel_r);
  assign out_item.data_byte = byte_r[rd_r[PW-1:0]];
  assign out_item.run_end   = rend_r[rd_r[PW-1:0]];
  assign out_item.frame_end = fend_r[rd_r[PW-1:0]];

  always_comb begin
    wr_nxt  = wr_r + (PW+1)'(push);
    rd_nxt  = rd_r + (PW+1)'(out_pop && !out_empty);
    rel_nxt = step.done ? rel_r + n : rel_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      rel_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      rel_r <= rel_nxt;
    end
  end

  // New bytes start unflagged; an item's end marks its last released byte.
  always_ff @(posedge clk) begin
    if (push) begin
      byte_r[wr_r[PW-1:0]] <= push_byte;
      rend_r[wr_r[PW-1:0]] <= 1'b0;
      fend_r[wr_r[PW-1:0]] <= 1'b0;
    end else if (step.done) begin
      if (n != '0) rend_r[PW'(rel_r + n - (PW+1)'(1))] <= 1'b1;
      if (step.last) fend_r[PW'(wr_r - (PW+1)'(1))] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gif_lzw_encoder_top.sv =====
// ----------------------------------------------------------------------------
// gif_lzw_encoder_top
// GIF LZW encoder: palette indices in, LSB-first packed code bytes out.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in_       input      in_push / in_full    pixel_index, last_pixel
// out_      output     out_empty / out_pop  data_byte, run_end, frame_end
//
// Each pixel but a frame's first is hashed, then read and compared once per dictionary
// probe; each code sent is merged and then drained, one byte per drain step.
// After reset the dictionary is swept through all 2^HASH_BITS slots with in_full high.
// Every 255th dictionary restart repeats that sweep before the next pixel.
// A stalled result side holds the engine once fewer than seven slots are free.
// ----------------------------------------------------------------------------
`default_nettype none

module gif_lzw_encoder_top #(
  parameter int HASH_BITS = glzw_pkg::HASH_BITS_DEF,
  parameter int MAX_CODES = glzw_pkg::MAX_CODES_DEF,
  parameter int ROOT_BITS = glzw_pkg::ROOT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire glzw_pkg::in_item_t  in_item,
  output logic                     in_full,
  input  wire logic                out_pop,
  output glzw_pkg::out_item_t      out_item,
  output logic                     out_empty
);

  logic               item_valid, item_pop, room, push, init_busy;
  logic [7:0]         push_byte;
  glzw_pkg::in_item_t item;
  glzw_pkg::step_t    step;

  // Input queue.
  glzw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_item    (in_item),
    .hold       (init_busy),
    .in_full    (in_full),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  // Dictionary engine and bit packer.
  glzw_back #(
    .HASH_BITS (HASH_BITS),
    .MAX_CODES (MAX_CODES),
    .ROOT_BITS (ROOT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .room       (room),
    .push       (push),
    .push_byte  (push_byte),
    .step       (step),
    .init_busy  (init_busy)
  );

  // Output queue.
  glzw_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_byte (push_byte),
    .step      (step),
    .room      (room),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

`default_nettype wire
